// ----- rtl/positional_list_table_top_macros.svh -----
// Assertion macros shared by the positional list table modules.
`ifndef POSITIONAL_LIST_TABLE_TOP_MACROS_SVH
`define POSITIONAL_LIST_TABLE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a property on every rising clock edge while reset is released.
`define PLT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("positional list table check failed");
// Checks that a condition in one cycle is followed by another in the next cycle.
`define PLT_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("positional list table sequence check failed");
`else
`define PLT_ASSERT(lbl, clk, rstn, prop)
`define PLT_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ----- rtl/plt_pkg.sv -----
// Types and constants shared by the positional list table modules.
package plt_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 3'd0,
    ACT_DELETE   = 3'd1,
    ACT_RETRIEVE = 3'd2,
    ACT_REPLACE  = 3'd3,
    ACT_CLEAR    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value_out;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic              is_full;
    logic [1:0]        status;
  } res_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// ----- rtl/plt_ctrl.sv -----
// Sequencer of the positional list table: accepts a request and starts its execution.
`include "positional_list_table_top_macros.svh"

module plt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output plt_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PLT_ASSERT_NEXT(a_accept_runs, clk_i, rst_ni, (state_q == S_IDLE) && start_i, state_q == S_EXEC)
  `PLT_ASSERT_NEXT(a_exec_single, clk_i, rst_ni, state_q == S_EXEC, state_q == S_IDLE)
  `PLT_ASSERT_NEXT(a_idle_waits, clk_i, rst_ni, (state_q == S_IDLE) && !start_i, state_q == S_IDLE)

endmodule

// ----- rtl/plt_dp.sv -----
// Datapath of the positional list table: entry cells, fill count and result register.
`include "positional_list_table_top_macros.svh"

module plt_dp #(
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  plt_pkg::cmd_t  cmd_i,
  input  plt_pkg::req_t  req_i,
  output logic           result_valid_o,
  output plt_pkg::res_t  result_o
);

  localparam int unsigned StoreW =
    (ENTRY_WIDTH < plt_pkg::DATA_W) ? ENTRY_WIDTH : plt_pkg::DATA_W;

  plt_pkg::req_t req_q;
  logic [plt_pkg::CNT_W-1:0] fill_q, fill_d;
  logic [StoreW-1:0] entries_q [plt_pkg::DEPTH];
  logic [StoreW-1:0] entries_d [plt_pkg::DEPTH];
  logic [StoreW-1:0] lower_e   [plt_pkg::DEPTH];
  logic [StoreW-1:0] upper_e   [plt_pkg::DEPTH];
  plt_pkg::res_t res_q, res_d;
  logic res_valid_q;

  logic [plt_pkg::POS_W-1:0] pos;
  logic [plt_pkg::IDX_W-1:0] idx;
  logic [StoreW-1:0] wval, rd;
  logic ins_ok, del_ok, rep_ok, clr;
  plt_pkg::status_e status;

  // Neighbor taps used when the list moves up or down by one place.
  always_comb begin
    lower_e[0] = entries_q[0];
    upper_e[plt_pkg::DEPTH-1] = entries_q[plt_pkg::DEPTH-1];
    for (int i = 1; i < plt_pkg::DEPTH; i++) begin
      lower_e[i] = entries_q[i-1];
    end
    for (int i = 0; i < plt_pkg::DEPTH - 1; i++) begin
      upper_e[i] = entries_q[i+1];
    end
  end

  always_comb begin
    pos    = req_q.position;
    idx    = pos[plt_pkg::IDX_W-1:0];
    wval   = req_q.value_in[StoreW-1:0];
    rd     = '0;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    rep_ok = 1'b0;
    clr    = 1'b0;
    status = plt_pkg::ST_OK;
    unique case (req_q.action)
      plt_pkg::ACT_INSERT: begin
        if (fill_q == plt_pkg::DEPTH_CNT) begin
          status = plt_pkg::ST_FULL;
        end else if (pos > fill_q) begin
          status = plt_pkg::ST_RANGE;
        end else begin
          ins_ok = 1'b1;
        end
      end
      plt_pkg::ACT_DELETE: begin
        if (pos >= fill_q) begin
          status = plt_pkg::ST_RANGE;
        end else begin
          del_ok = 1'b1;
          rd     = entries_q[idx];
        end
      end
      plt_pkg::ACT_RETRIEVE: begin
        if (pos >= fill_q) begin
          status = plt_pkg::ST_RANGE;
        end else begin
          rd = entries_q[idx];
        end
      end
      plt_pkg::ACT_REPLACE: begin
        if (pos >= fill_q) begin
          status = plt_pkg::ST_RANGE;
        end else begin
          rep_ok = 1'b1;
        end
      end
      plt_pkg::ACT_CLEAR: begin
        clr = 1'b1;
      end
      default: ;
    endcase
  end

  // Every cell picks its own next value; the whole list moves in one step.
  always_comb begin
    for (int i = 0; i < plt_pkg::DEPTH; i++) begin
      entries_d[i] = entries_q[i];
      if (ins_ok) begin
        if (plt_pkg::POS_W'(i) == pos) begin
          entries_d[i] = wval;
        end else if (plt_pkg::POS_W'(i) > pos) begin
          entries_d[i] = lower_e[i];
        end
      end else if (del_ok) begin
        if (plt_pkg::POS_W'(i) >= pos) begin
          entries_d[i] = upper_e[i];
        end
      end else if (rep_ok) begin
        if (plt_pkg::POS_W'(i) == pos) begin
          entries_d[i] = wval;
        end
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (clr) begin
      fill_d = '0;
    end else if (ins_ok) begin
      fill_d = fill_q + 1'b1;
    end else if (del_ok) begin
      fill_d = fill_q - 1'b1;
    end
    res_d.value_out = plt_pkg::DATA_W'(rd);
    res_d.count     = fill_d;
    res_d.is_empty  = (fill_d == '0);
    res_d.is_full   = (fill_d == plt_pkg::DEPTH_CNT);
    res_d.status    = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      res_q     <= res_d;
      entries_q <= entries_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `PLT_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= plt_pkg::DEPTH_CNT)
  `PLT_ASSERT_NEXT(a_fill_hold, clk_i, rst_ni, !cmd_i.exec, $stable(fill_q))
  `PLT_ASSERT(a_flags_match, clk_i, rst_ni, !res_valid_q || (res_q.is_empty == (res_q.count == '0)))

endmodule

// ----- rtl/positional_list_table_top.sv -----
// Top level of the positional list table: request handshake, sequencer and datapath.
//
// The block keeps an ordered list of up to sixteen entries. A request transaction is
// accepted at a rising clock edge where start is high and busy is low; it carries an
// action (insert, delete, retrieve, replace or clear), a zero-based position and a
// value. The request executes in the cycle after acceptance, and its result appears on
// result_o for exactly one clock cycle, marked by result_valid_o, starting the cycle
// after that. The receiver cannot hold results off, so a result must be captured in
// the cycle its strobe is high. Each transaction is accepted in the idle state and then
// executed in the execute state of the sequencer, which runs the single execute step of
// the entry cells. busy is high during the execute cycle and low while a result is shown,
// so a new request may be accepted in the same cycle that the previous result is taken.
// Inserts move later entries up one place and deletes move them down, all cells in
// parallel. A refused request (insert into a full list or a position out of range)
// leaves the list unchanged and returns value zero with an error status. Action codes
// above clear do nothing and report success. Entries hold ENTRY_WIDTH bits of the
// written value, at most 32, and read back zero-extended.

module positional_list_table_top #(
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  plt_pkg::req_t  req_i,
  output logic           result_valid_o,
  output plt_pkg::res_t  result_o
);

  // Commands from the sequencer to the datapath.
  plt_pkg::cmd_t cmd;

  plt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  plt_dp #(
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
